>>> hw/rtl/two_axis_sine_profile_stepper_assert.svh
// Assertion macros for the two-axis stepper checker
`ifndef TWO_AXIS_SINE_PROFILE_STEPPER_ASSERT_SVH
`define TWO_AXIS_SINE_PROFILE_STEPPER_ASSERT_SVH

// clocked property, ignored while reset is held
`define TSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define TSPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tsps_pkg.sv
// Shared constants for the two-axis sine profile stepper
`timescale 1ns / 1ps
package tsps_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF    = 15;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_ADDR_W-1:0] CFG_TICK  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INV_A = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INV_B = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONST = 2'd3;

  localparam int TICK_W = 10;
  localparam logic [TICK_W-1:0] TICK_RESET = 10'd100;
  localparam int DUR_W  = 31;
  localparam int FIELD_W = 16;

  localparam int PI_W = 18;
  localparam logic [PI_W-1:0] PI_Q16 = 18'd205887;
  localparam int KT_W = PI_W + TICK_W;

  localparam int EDGE_STEPS = 10;
  localparam int RAD_W      = 46;
  localparam logic [63:0] RAD_LIMIT = (64'd1 << RAD_W) - 64'd1;
  localparam int FRAC_SHIFT = 16;

  localparam int SQ_IN_W  = RAD_W + FRAC_SHIFT;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int DEN_W    = KT_W + SQ_OUT_W;
  localparam int DIV_W    = DEN_W + 1;
  localparam int DUR_SHIFT = 25;

endpackage

>>> hw/rtl/tsps_if.sv
// Valid/ready channel interfaces for stepper commands and results
`timescale 1ns / 1ps
interface tsps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] target_a;
  logic signed [15:0] target_b;
  logic [30:0]        duration_us;
  modport source (output valid, operation, target_a, target_b, duration_us, input ready);
  modport sink (input valid, operation, target_a, target_b, duration_us, output ready);
endinterface

interface tsps_out_if;
  logic               valid;
  logic               ready;
  logic               pulse_a;
  logic               pulse_b;
  logic               dir_a;
  logic               dir_b;
  logic               drivers_enabled;
  logic signed [15:0] position_a;
  logic signed [15:0] position_b;
  modport source (output valid, pulse_a, pulse_b, dir_a, dir_b, drivers_enabled,
                  position_a, position_b, input ready);
  modport sink (input valid, pulse_a, pulse_b, dir_a, dir_b, drivers_enabled,
                position_a, position_b, output ready);
endinterface

>>> hw/rtl/two_axis_sine_profile_stepper.sv
// Top level: two-axis step/direction generator with sine velocity profile
`timescale 1ns / 1ps
// Usage:
//  in_ch  : command words (tick, start motion, emergency stop), valid/ready.
//  out_ch : one result word per command: pulses, direction levels, driver
//           enable and both positions after the command.
//  cfg_*  : write-only registers (tick period, direction inverts, constant
//           speed); write only while no command is in flight.
// Command flow:
//  start, stop and ticks that step no axis go straight to ST_OUT, which
//  loads the result word into the output register once it is free.
//  A tick that steps an axis computes its next interval serially in
//  ST_CLAMP, ST_MUL, ST_RAD, ST_ROOT (two radicand bits per cycle),
//  ST_DEN, ST_DIVLD and ST_DIV (one bit per cycle), then ST_WB, once per
//  stepping axis; constant speed skips the root.
//  One command is worked at a time; the next is taken as soon as the
//  sequencer is idle, even while the last result word waits in out_ch.
// Reset: synchronous rst_n clears positions, targets, counters, drive enable
//  and the registers to their defaults (tick 100, invert_b set).
// Stall: a held result word stays put; the sequencer waits for the output
//  register to free before loading the next one.
module two_axis_sine_profile_stepper import tsps_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tsps_in_if.sink               in_ch,
  tsps_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int PW  = POSITION_BITS;
  localparam int DW  = PW + 2;       // signed room for d, x and clamp
  localparam int RPW = 2 * DW;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic signed [DW-1:0] EDGE_S = DW'(EDGE_STEPS);

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLAMP = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_RAD   = 4'd3;
  localparam logic [3:0] ST_ROOT  = 4'd4;
  localparam logic [3:0] ST_DEN   = 4'd5;
  localparam logic [3:0] ST_DIVLD = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_WB    = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  // config
  logic [TICK_W-1:0] tick_r;
  logic              inv_a_r, inv_b_r, const_r;

  // axis state
  logic signed [PW-1:0]   cur_r [2];
  logic signed [PW-1:0]   tgt_r [2];
  logic signed [PW-1:0]   st_r  [2];
  logic                   neg_r [2];
  logic [COUNT_BITS-1:0]  wait_r [2];
  logic                   running_r;
  logic [DUR_W-1:0]       dur_r;

  // sequencer and datapath
  logic [3:0]             state_r;
  logic [1:0]             need_r;
  logic [1:0]             pulse_r;
  logic                   sel_r;
  logic signed [DW-1:0]   d_r, bx_r;
  logic signed [RPW-1:0]  rad_r;
  logic [KT_W-1:0]        ktick_r;
  logic [DEN_W-1:0]       den_r;
  logic [COUNT_BITS-1:0]  reload_r;

  // output register
  logic                   ov_r;
  logic                   o_pa_r, o_pb_r, o_da_r, o_db_r, o_en_r;
  logic signed [FIELD_W-1:0] o_posa_r, o_posb_r;

  // combinational
  logic                   acc;
  logic [1:0]             at_tgt;
  logic signed [DW-1:0]   dd, dx, d_abs, x_abs, bx;
  logic [63:0]            rad_u;
  logic [RAD_W-1:0]       rad_c;
  logic                   sq_start, sq_done;
  logic [SQ_OUT_W-1:0]    sq_root;
  logic                   dv_start, dv_done;
  logic [DIV_W-1:0]       dv_num, dv_den, dv_quo;
  logic                   out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_free    = !ov_r || out_ch.ready;

  assign at_tgt[0] = (cur_r[0] == tgt_r[0]);
  assign at_tgt[1] = (cur_r[1] == tgt_r[1]);

  // move length and steps done for the selected axis, clamped to the edges
  always_comb begin
    dd    = DW'(st_r[sel_r]) - DW'(tgt_r[sel_r]);
    dx    = DW'(st_r[sel_r]) - DW'(cur_r[sel_r]);
    d_abs = (dd < 0) ? -dd : dd;
    x_abs = (dx < 0) ? -dx : dx;
    if (x_abs < EDGE_S) begin
      bx = EDGE_S;
    end else if (x_abs > d_abs - EDGE_S) begin
      bx = d_abs - EDGE_S;
    end else begin
      bx = x_abs;
    end
  end

  // radicand clamp, then 8 fraction bits on the root
  assign rad_u = 64'(rad_r);
  assign rad_c = (rad_u > RAD_LIMIT) ? RAD_W'(RAD_LIMIT) : rad_u[RAD_W-1:0];

  assign sq_start = (state_r == ST_RAD) && !const_r && (rad_r > 0);
  assign dv_start = (state_r == ST_DIVLD) && (den_r != '0);

  // sine: round-half-up of T*2^24 / den; constant: trunc(T / (d*tick))
  assign dv_num = const_r ? DIV_W'(dur_r)
                          : (DIV_W'(dur_r) << DUR_SHIFT) + DIV_W'(den_r);
  assign dv_den = const_r ? DIV_W'(den_r) : (DIV_W'(den_r) << 1);

  tsps_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({rad_c, {FRAC_SHIFT{1'b0}}}),
    .done     (sq_done),
    .root     (sq_root)
  );

  tsps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= TICK_RESET;
      inv_a_r   <= 1'b0;
      inv_b_r   <= 1'b1;
      const_r   <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        cur_r[i]  <= '0;
        tgt_r[i]  <= '0;
        st_r[i]   <= '0;
        neg_r[i]  <= 1'b0;
        wait_r[i] <= '0;
      end
      running_r <= 1'b0;
      dur_r     <= '0;
      state_r   <= ST_IDLE;
      need_r    <= '0;
      pulse_r   <= '0;
      sel_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TICK:  tick_r  <= cfg_wdata[TICK_W-1:0];
          CFG_INV_A: inv_a_r <= cfg_wdata[0];
          CFG_INV_B: inv_b_r <= cfg_wdata[0];
          CFG_CONST: const_r <= cfg_wdata[0];
          default:   ;
        endcase
      end

      // ST_OUT owns the output register while it loads a word
      if (ov_r && out_ch.ready && state_r != ST_OUT) begin
        ov_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            pulse_r <= '0;
            need_r  <= '0;
            state_r <= ST_OUT;
            case (in_ch.operation)
              OP_START: begin
                tgt_r[0] <= PW'(in_ch.target_a);
                tgt_r[1] <= PW'(in_ch.target_b);
                dur_r    <= in_ch.duration_us;
                for (int i = 0; i < 2; i++) begin
                  st_r[i]   <= cur_r[i];
                  wait_r[i] <= '0;
                end
                neg_r[0]  <= !(PW'(in_ch.target_a) > cur_r[0]);
                neg_r[1]  <= !(PW'(in_ch.target_b) > cur_r[1]);
                running_r <= 1'b1;
              end
              OP_STOP: begin
                running_r <= 1'b0;
              end
              OP_TICK: begin
                if (running_r) begin
                  for (int i = 0; i < 2; i++) begin
                    if (!at_tgt[i] && wait_r[i] != '0) begin
                      wait_r[i] <= wait_r[i] - 1'b1;
                    end
                  end
                  need_r[0]  <= !at_tgt[0] && (wait_r[0] == '0);
                  need_r[1]  <= !at_tgt[1] && (wait_r[1] == '0);
                  pulse_r[0] <= !at_tgt[0] && (wait_r[0] == '0);
                  pulse_r[1] <= !at_tgt[1] && (wait_r[1] == '0);
                  if (at_tgt[0] && at_tgt[1]) begin
                    running_r <= 1'b0;
                  end
                  if ((!at_tgt[0] && wait_r[0] == '0) ||
                      (!at_tgt[1] && wait_r[1] == '0)) begin
                    sel_r   <= !(!at_tgt[0] && wait_r[0] == '0);
                    state_r <= ST_CLAMP;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_CLAMP: begin
          d_r     <= d_abs;
          bx_r    <= bx;
          ktick_r <= KT_W'(PI_Q16) * KT_W'(tick_r);
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          rad_r   <= RPW'(bx_r) * RPW'(d_r - bx_r);
          den_r   <= DEN_W'(d_r[PW-1:0]) * DEN_W'(tick_r);
          state_r <= ST_RAD;
        end
        ST_RAD: begin
          if (const_r) begin
            state_r <= ST_DIVLD;
          end else if (rad_r > 0) begin
            state_r <= ST_ROOT;
          end else begin
            reload_r <= CNT_MAX;   // short move: no root
            state_r  <= ST_WB;
          end
        end
        ST_ROOT: begin
          if (sq_done) begin
            state_r <= ST_DEN;
          end
        end
        ST_DEN: begin
          den_r   <= DEN_W'(ktick_r) * DEN_W'(sq_root);
          state_r <= ST_DIVLD;
        end
        ST_DIVLD: begin
          if (den_r == '0) begin
            reload_r <= CNT_MAX;
            state_r  <= ST_WB;
          end else begin
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dv_done) begin
            reload_r <= (dv_quo > DIV_W'(CNT_MAX)) ? CNT_MAX : dv_quo[COUNT_BITS-1:0];
            state_r  <= ST_WB;
          end
        end
        ST_WB: begin
          wait_r[sel_r] <= reload_r;
          cur_r[sel_r]  <= neg_r[sel_r] ? cur_r[sel_r] - 1'b1 : cur_r[sel_r] + 1'b1;
          if (!sel_r && need_r[1]) begin
            sel_r   <= 1'b1;
            state_r <= ST_CLAMP;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            ov_r     <= 1'b1;
            o_pa_r   <= pulse_r[0];
            o_pb_r   <= pulse_r[1];
            o_da_r   <= inv_a_r ^ neg_r[0];
            o_db_r   <= inv_b_r ^ neg_r[1];
            o_en_r   <= running_r;
            o_posa_r <= FIELD_W'(cur_r[0]);
            o_posb_r <= FIELD_W'(cur_r[1]);
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.pulse_a         = o_pa_r;
  assign out_ch.pulse_b         = o_pb_r;
  assign out_ch.dir_a           = o_da_r;
  assign out_ch.dir_b           = o_db_r;
  assign out_ch.drivers_enabled = o_en_r;
  assign out_ch.position_a      = o_posa_r;
  assign out_ch.position_b      = o_posb_r;
endmodule

>>> hw/rtl/tsps_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module tsps_sqrt import tsps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  radicand,
  output logic                done,
  output logic [SQ_OUT_W-1:0] root
);
  localparam int REM_W = SQ_OUT_W + 3;
  localparam int CW    = $clog2(SQ_OUT_W + 1);

  logic [SQ_IN_W-1:0]  src_r;
  logic [REM_W-1:0]    rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                ge;

  assign rem_sh = {rem_r[REM_W-3:0], src_r[SQ_IN_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        src_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(SQ_OUT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        src_r  <= src_r << 2;
        rem_r  <= ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[SQ_OUT_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

>>> hw/rtl/tsps_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tsps_div import tsps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);
  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] qn_r;   // numerator shifts out, quotient shifts in
  logic [DIV_W-1:0] den_r;
  logic [DIV_W-1:0] rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, qn_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        qn_r   <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CW'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? DIV_W'(rem_sh - {1'b0, den_r}) : DIV_W'(rem_sh);
        qn_r   <= {qn_r[DIV_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = qn_r;
endmodule

>>> hw/rtl/tsps_check.sv
// Port-level checker for the stepper, bound to the top level
`timescale 1ns / 1ps
`include "two_axis_sine_profile_stepper_assert.svh"
module tsps_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pulse_a,
  input logic pulse_b,
  input logic drivers_enabled
);
  `TSPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result word dropped")
  `TSPS_ASSERT(a_pulse_en, out_valid && (pulse_a || pulse_b) |-> drivers_enabled, "pulse with drivers off")
  `TSPS_ASSERT(a_one_word, in_valid && in_ready |=> !in_ready, "second command taken while busy")
  `TSPS_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result word right after reset")
endmodule

bind two_axis_sine_profile_stepper tsps_check u_tsps_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .pulse_a         (out_ch.pulse_a),
  .pulse_b         (out_ch.pulse_b),
  .drivers_enabled (out_ch.drivers_enabled)
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the two-axis sine profile stepper
`timescale 1ns / 1ps
module tb_top;
  import tsps_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tsps_in_if  in_ch();
  tsps_out_if out_ch();

  two_axis_sine_profile_stepper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // one command word and one result word
  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] ta;
    logic signed [15:0] tb;
    logic [30:0]        du;
  } cmd_t;

  typedef struct {
    logic               pa;
    logic               pb;
    logic               da;
    logic               db;
    logic               en;
    logic signed [15:0] qa;
    logic signed [15:0] qb;
  } step_out_t;

  localparam int MAX_WAIT = 32767;
  localparam int WATCHDOG = 5000;
  localparam int TAIL     = 400;

  // shadow copy of the stepper state
  logic signed [15:0] sh_pos [2];
  logic signed [15:0] sh_tgt [2];
  logic signed [15:0] sh_org [2];
  logic               sh_neg [2];
  logic [14:0]        sh_wait [2];
  logic               sh_run;
  logic [30:0]        sh_dur;
  // shadow registers
  logic [9:0]         sh_tick;
  logic               sh_inv_a;
  logic               sh_inv_b;
  logic               sh_const;

  cmd_t      pending_cmds[$];
  step_out_t expected_steps[$];
  int        n_cmds;
  int        n_err;
  bit        quiet;    // no idling in the closing stretch
  bit        done;
  int        in_gap;
  int        out_stall;
  int        idle_cycles;

  // integer square root, two bits per pass
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // interval to the next pulse of one axis
  function automatic logic [14:0] step_interval(int ax);
    longint d, x, bx, rad;
    longint unsigned den, q, s, t;
    d = longint'(sh_org[ax]) - longint'(sh_tgt[ax]);
    x = longint'(sh_org[ax]) - longint'(sh_pos[ax]);
    t = sh_dur;
    if (d < 0) d = -d;
    if (x < 0) x = -x;
    if (sh_const) begin
      den = d * sh_tick;
      if (den == 0) return 15'(MAX_WAIT);
      q = t / den;
      return (q > MAX_WAIT) ? 15'(MAX_WAIT) : q[14:0];
    end
    // hold the profile off its zero ends
    bx = x;
    if (bx < EDGE_STEPS) bx = EDGE_STEPS;
    else if (bx > d - EDGE_STEPS) bx = d - EDGE_STEPS;
    rad = bx * (d - bx);
    if (rad <= 0) return 15'(MAX_WAIT);   // short move: no real root
    if (rad > RAD_LIMIT) rad = RAD_LIMIT;
    s   = int_sqrt(longint'(rad) << 16);
    den = longint'(PI_Q16) * sh_tick * s;
    if (den == 0) return 15'(MAX_WAIT);
    q = (2 * (t << 24) + den) / (2 * den);   // rounded half up
    return (q > MAX_WAIT) ? 15'(MAX_WAIT) : q[14:0];
  endfunction

  // advance the shadow state by one accepted command
  function automatic step_out_t advance(cmd_t c);
    step_out_t r;
    int at_target;
    r.pa = 0;
    r.pb = 0;
    at_target = 0;
    if (c.op == OP_START) begin
      sh_tgt[0] = c.ta;
      sh_tgt[1] = c.tb;
      sh_dur    = c.du;
      for (int i = 0; i < 2; i++) begin
        sh_org[i]  = sh_pos[i];
        sh_wait[i] = 0;
        sh_neg[i]  = !(sh_tgt[i] > sh_pos[i]);
      end
      sh_run = 1;
    end else if (c.op == OP_STOP) begin
      sh_run = 0;
    end else if (c.op == OP_TICK && sh_run) begin
      for (int i = 0; i < 2; i++) begin
        if (sh_pos[i] == sh_tgt[i]) begin
          at_target++;
        end else if (sh_wait[i] != 0) begin
          sh_wait[i]--;
        end else begin
          sh_wait[i] = step_interval(i);
          if (i == 0) r.pa = 1;
          else r.pb = 1;
          sh_pos[i] = sh_neg[i] ? sh_pos[i] - 16'sd1 : sh_pos[i] + 16'sd1;
        end
      end
      if (at_target >= 2) sh_run = 0;
    end
    r.da = sh_inv_a ^ sh_neg[0];
    r.db = sh_inv_b ^ sh_neg[1];
    r.en = sh_run;
    r.qa = sh_pos[0];
    r.qb = sh_pos[1];
    return r;
  endfunction

  // clock; all inputs known from time zero
  initial begin
    clk             = 0;
    rst_n           = 0;
    cfg_we          = 0;
    cfg_addr        = CFG_TICK;
    cfg_wdata       = '0;
    in_ch.valid     = 0;
    in_ch.operation = OP_TICK;
    in_ch.target_a  = '0;
    in_ch.target_b  = '0;
    in_ch.duration_us = '0;
    out_ch.ready    = 0;
    forever #2 clk = ~clk;
  end

  // driver: one command word per handshake, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cmd_t c;
        c.op = in_ch.operation;
        c.ta = in_ch.target_a;
        c.tb = in_ch.target_b;
        c.du = in_ch.duration_us;
        expected_steps.push_back(advance(c));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 0;
        end else if (pending_cmds.size() > 0) begin
          cmd_t w;
          w = pending_cmds.pop_front();
          in_ch.operation   <= w.op;
          in_ch.target_a    <= w.ta;
          in_ch.target_b    <= w.tb;
          in_ch.duration_us <= w.du;
          in_ch.valid       <= 1;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 16);
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // monitor: result words against the oldest expectation, random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result word pulse=%b%b pos=%0d,%0d", $time,
                   out_ch.pulse_a, out_ch.pulse_b, out_ch.position_a, out_ch.position_b);
          n_err++;
        end else begin
          step_out_t e;
          e = expected_steps.pop_front();
          if (out_ch.pulse_a !== e.pa || out_ch.pulse_b !== e.pb ||
              out_ch.dir_a !== e.da || out_ch.dir_b !== e.db ||
              out_ch.drivers_enabled !== e.en ||
              out_ch.position_a !== e.qa || out_ch.position_b !== e.qb) begin
            $display("%0t: mismatch exp pulse=%b%b dir=%b%b en=%b pos=%0d,%0d", $time,
                     e.pa, e.pb, e.da, e.db, e.en, e.qa, e.qb);
            $display("%0t:          got pulse=%b%b dir=%b%b en=%b pos=%0d,%0d", $time,
                     out_ch.pulse_a, out_ch.pulse_b, out_ch.dir_a, out_ch.dir_b,
                     out_ch.drivers_enabled, out_ch.position_a, out_ch.position_b);
            n_err++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 0;
      end else begin
        if (!quiet && $urandom_range(0, 19) == 0) out_stall = $urandom_range(1, 16);
        out_ch.ready <= 1;
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (!done) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] op, int ta = 0, int tb = 0, logic [30:0] du = 0);
    cmd_t c;
    c.op = op;
    c.ta = ta[15:0];
    c.tb = tb[15:0];
    c.du = du;
    pending_cmds.push_back(c);
    n_cmds++;
  endtask

  // every queued word accepted; shadow state is then current
  task automatic wait_sent();
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_sent();
    wait (expected_steps.size() == 0);
    @(posedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic reg_write(logic [CFG_ADDR_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_TICK:  sh_tick  = val[9:0];
      CFG_INV_A: sh_inv_a = val[0];
      CFG_INV_B: sh_inv_b = val[0];
      default:   sh_const = val[0];
    endcase
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // move length: mostly long enough for a real profile, sometimes tiny
  function automatic int pick_delta();
    int m;
    m = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(11, 30);
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  // one move: start, ticks in batches until arrival, stop if it drags on
  task automatic run_move();
    int ta, tb, dmax, batches;
    logic [30:0] du;
    ta = clamp16(sh_pos[0] + pick_delta());
    tb = clamp16(sh_pos[1] + pick_delta());
    dmax = 30;
    if ($urandom_range(0, 7) == 0) du = 31'($urandom);   // any duration, long waits
    else if (sh_const) du = 31'($urandom_range(0, 3 * dmax * sh_tick));
    else du = 31'($urandom_range(0, 40 * sh_tick));
    send(OP_START, ta, tb, du);
    batches = 0;
    forever begin
      repeat (8) begin
        if ($urandom_range(0, 29) == 0) send(OP_NOP, $urandom, $urandom, 31'($urandom));
        else send(OP_TICK, $urandom, $urandom, 31'($urandom));
      end
      wait_sent();
      batches++;
      if (!sh_run) break;
      if (batches >= 12 || $urandom_range(0, 39) == 0) begin
        send(OP_STOP, $urandom, $urandom, 31'($urandom));
        break;
      end
    end
  endtask

  initial begin
    int ph;
    sh_tick  = TICK_RESET;
    sh_inv_a = 0;
    sh_inv_b = 1;
    sh_const = 0;
    sh_run   = 0;
    sh_dur   = 0;
    for (int i = 0; i < 2; i++) begin
      sh_pos[i]  = 0;
      sh_tgt[i]  = 0;
      sh_org[i]  = 0;
      sh_neg[i]  = 0;
      sh_wait[i] = 0;
    end
    n_cmds = 0;
    n_err  = 0;
    quiet  = 0;
    done   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed: idle tick, unknown op, far extremes then stop
    send(OP_TICK);
    send(OP_NOP, -1, -1, 31'h7fffffff);
    send(OP_START, 32767, -32768, 31'h7fffffff);
    repeat (3) send(OP_TICK);
    send(OP_STOP);
    send(OP_TICK);                        // tick while disabled
    wait_sent();
    // target equal to position: both axes already home
    send(OP_START, sh_pos[0], sh_pos[1], 1000);
    send(OP_TICK);
    send(OP_TICK);
    wait_sent();
    // zero duration, short move below the profile edge (saturated wait)
    send(OP_START, sh_pos[0] - 1, sh_pos[1] + 3, 0);
    repeat (3) send(OP_TICK);
    send(OP_STOP);
    wait_drained();
    reg_write(CFG_CONST, 1);
    send(OP_START, sh_pos[0] + 12, sh_pos[1] - 12, 0);
    repeat (6) send(OP_TICK);
    send(OP_STOP);
    wait_drained();

    // random phases, a register setting per phase
    ph = 0;
    while (n_cmds < 1650) begin
      wait_drained();
      case (ph % 4)
        0: begin
          reg_write(CFG_TICK, 1000);
          reg_write(CFG_INV_A, 0);
          reg_write(CFG_INV_B, 1);
          reg_write(CFG_CONST, 0);
        end
        1: begin
          reg_write(CFG_TICK, 1);
          reg_write(CFG_INV_A, 1);
          reg_write(CFG_INV_B, 0);
          reg_write(CFG_CONST, 1);
        end
        default: begin
          reg_write(CFG_TICK, $urandom_range(1, 1000));
          reg_write(CFG_INV_A, $urandom_range(0, 1));
          reg_write(CFG_INV_B, $urandom_range(0, 1));
          reg_write(CFG_CONST, $urandom_range(0, 1));
        end
      endcase
      for (int m = 0; m < 6 && n_cmds < 1650; m++) begin
        if (n_cmds > 1450) quiet = 1;
        run_move();
      end
      ph++;
    end

    wait_drained();
    repeat (TAIL) @(posedge clk);
    done = 1;
    if (n_err == 0 && expected_steps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
